@@ hdl/scq_pkg.sv @@
// Shared types and constants of the symmetry quaternion canonicalizer.
`timescale 1ns / 1ps

package scq_pkg;

  // Fixed field widths of the input word and the register file
  localparam int ENTRY_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 3;

  // Operation codes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_W      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR_Z      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QSCORE,
    ST_QWAIT,
    ST_PROD,
    ST_PWAIT,
    ST_SCORE,
    ST_SWAIT,
    ST_DONE
  } scq_state_t;

  // What a pass through the dot unit computes
  typedef enum logic {
    TAG_COMP,
    TAG_SCORE
  } tag_kind_t;

  // Tag that travels with an operation through the dot unit
  typedef struct packed {
    logic      valid;
    tag_kind_t kind;
    logic [1:0] comp;
  } dot_tag_t;

endpackage

@@ hdl/scq_in_if.sv @@
// Input channel: table writes and queries.
`timescale 1ns / 1ps

interface scq_in_if #(
  parameter int CW = 16
);
  import scq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic [ENTRY_W-1:0]   entry_index;
  logic signed [CW-1:0] comp_w;
  logic signed [CW-1:0] comp_x;
  logic signed [CW-1:0] comp_y;
  logic signed [CW-1:0] comp_z;

  modport source (
    output valid, operation, entry_index, comp_w, comp_x, comp_y, comp_z,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, comp_w, comp_x, comp_y, comp_z,
    output ready
  );
endinterface

@@ hdl/scq_out_if.sv @@
// Result channel: chosen quaternion and slot.
`timescale 1ns / 1ps

interface scq_out_if #(
  parameter int CW = 16,
  parameter int SW = 7
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] best_w;
  logic signed [CW-1:0] best_x;
  logic signed [CW-1:0] best_y;
  logic signed [CW-1:0] best_z;
  logic [SW-1:0]        chosen_slot;

  modport source (
    output valid, best_w, best_x, best_y, best_z, chosen_slot,
    input  ready
  );
  modport sink (
    input  valid, best_w, best_x, best_y, best_z, chosen_slot,
    output ready
  );
endinterface

@@ hdl/scq_cfg_if.sv @@
// Configuration write channel.
`timescale 1ns / 1ps

interface scq_cfg_if #(
  parameter int DW = 16
);
  import scq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DW-1:0]        data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ hdl/symmetry_quaternion_canonicalizer.sv @@
// Top level: sequencer, registers and result stage of the canonicalizer.
//
// Usage: words on in_if either load a table slot (operation write) or query a
// quaternion (operation query). A query scores the query itself and then, for
// each of the N = min(element_count, MAX_ELEMENTS) loaded slots, the product
// conj(entry) * query against the anchor; the best candidate leaves on out_if.
// Registers are written over cfg_if (always ready); the user must write them
// only while the block is idle, which the block itself does not enforce.
// Timing: a table write gives no result. A query brings out_valid after its
// last score is back and the output register is free. Each element takes
// four component passes and one scoring pass through the shared four-lane
// multiply/sum pipeline; the scoring pass waits for the fourth component.
// Reset: anchor returns to (max, 0, 0, 0), element_count to 0; table contents
// are undefined until written, there is no clearing pass.
// Stall: the result sits in an output register, so the block keeps taking
// words; a query that finishes while that register is still full waits in
// its final step until the receiver takes the pending word.
`timescale 1ns / 1ps

module symmetry_quaternion_canonicalizer #(
  parameter int MAX_ELEMENTS   = 64,
  parameter int COMPONENT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  scq_in_if.sink   in_if,
  scq_out_if.source out_if,
  scq_cfg_if.sink  cfg_if
);
  import scq_pkg::*;

  localparam int CW    = COMPONENT_BITS;
  localparam int F     = CW - 1;
  localparam int OW    = CW + 1;
  localparam int SUM_W = 2 * OW + 2;
  localparam int SW    = $clog2(MAX_ELEMENTS + 1);
  localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  localparam logic signed [CW-1:0]    ANCHOR_W_RST = {1'b0, {F{1'b1}}};
  localparam logic signed [SUM_W-1:0] HALF_LSB     = {{(SUM_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SAT_HI       = {{(SUM_W-F){1'b0}}, {F{1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO       = {{(SUM_W-F){1'b1}}, {F{1'b0}}};
  localparam logic [SW-1:0]           SLOT_SELF    = SW'(MAX_ELEMENTS);

  // Registers
  logic signed [CW-1:0] anchor_r [4];
  logic [COUNT_W-1:0]   count_r;

  // Sequencer and datapath state
  scq_state_t           state_r, state_nxt;
  logic [1:0]           phase_r;
  logic [SW-1:0]        idx_r;
  logic [SW-1:0]        cnt_r;
  logic [SW-1:0]        cnt_eff;
  logic signed [CW-1:0] q_r [4];
  logic signed [CW-1:0] p_r [4];
  logic signed [CW-1:0] best_r [4];
  logic [SUM_W-1:0]     best_score_r;
  logic [SW-1:0]        slot_r;

  // Output register
  logic                 out_valid_r;
  logic signed [CW-1:0] out_comp_r [4];
  logic [SW-1:0]        out_slot_r;

  // Control
  logic                 in_ready;
  logic                 in_acc;
  logic                 query_acc;
  logic                 tbl_wr_en;
  logic                 tbl_rd_en;
  logic [SW-1:0]        rd_idx;
  logic [4*CW-1:0]      tbl_wr_data;
  logic [4*CW-1:0]      tbl_rd_data;
  logic                 out_load;
  logic                 last_elem;

  // Dot unit connection
  dot_tag_t                iss_tag;
  dot_tag_t                res_tag;
  logic signed [OW-1:0]    a_op [4];
  logic signed [OW-1:0]    b_op [4];
  logic signed [SUM_W-1:0] res_sum;
  logic                    res_comp;
  logic                    res_score;

  // Result post-processing
  logic signed [SUM_W-1:0] rnd_sum;
  logic signed [SUM_W-1:0] rnd_shr;
  logic signed [CW-1:0]    comp_sat;
  logic [SUM_W-1:0]        score;

  // Extended operands
  logic signed [OW-1:0] q_e [4];
  logic signed [OW-1:0] q_n [4];
  logic signed [OW-1:0] s_e [4];
  logic signed [OW-1:0] p_e [4];
  logic signed [OW-1:0] anc_e [4];

  // Register writes; indexes past the list are dropped
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r[0] <= ANCHOR_W_RST;
      anchor_r[1] <= '0;
      anchor_r[2] <= '0;
      anchor_r[3] <= '0;
      count_r     <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_ANCHOR_W:      anchor_r[0] <= cfg_if.data[CW-1:0];
        CFG_ANCHOR_X:      anchor_r[1] <= cfg_if.data[CW-1:0];
        CFG_ANCHOR_Y:      anchor_r[2] <= cfg_if.data[CW-1:0];
        CFG_ANCHOR_Z:      anchor_r[3] <= cfg_if.data[CW-1:0];
        CFG_ELEMENT_COUNT: count_r     <= cfg_if.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept and table write
  assign in_acc      = in_if.valid && in_ready;
  assign query_acc   = in_acc && (in_if.operation == OP_QUERY);
  assign tbl_wr_en   = in_acc && (in_if.operation == OP_WRITE) &&
                       (32'(in_if.entry_index) < MAX_ELEMENTS);
  assign tbl_wr_data = {in_if.comp_z, in_if.comp_y, in_if.comp_x, in_if.comp_w};
  assign cnt_eff     = (32'(count_r) > MAX_ELEMENTS) ? SLOT_SELF : SW'(count_r);

  scq_table #(
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW),
    .DW    (4 * CW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (AW'(in_if.entry_index)),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (tbl_rd_data)
  );

  // Sign-extended and negated operand copies
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      q_e[k]   = {q_r[k][CW-1], q_r[k]};
      q_n[k]   = -q_e[k];
      s_e[k]   = {tbl_rd_data[k*CW+CW-1], tbl_rd_data[k*CW +: CW]};
      p_e[k]   = {p_r[k][CW-1], p_r[k]};
      anc_e[k] = {anchor_r[k][CW-1], anchor_r[k]};
    end
  end

  scq_dot_unit #(
    .OW (OW)
  ) u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss_tag (iss_tag),
    .a_op    (a_op),
    .b_op    (b_op),
    .res_tag (res_tag),
    .res_sum (res_sum)
  );

  assign res_comp  = res_tag.valid && (res_tag.kind == TAG_COMP);
  assign res_score = res_tag.valid && (res_tag.kind == TAG_SCORE);
  assign last_elem = ((idx_r + SW'(1)) == cnt_r);

  // Round half up to Q1.F, then saturate
  assign rnd_sum = res_sum + HALF_LSB;
  assign rnd_shr = rnd_sum >>> F;
  always_comb begin
    if (rnd_shr > SAT_HI) begin
      comp_sat = SAT_HI[CW-1:0];
    end else if (rnd_shr < SAT_LO) begin
      comp_sat = SAT_LO[CW-1:0];
    end else begin
      comp_sat = rnd_shr[CW-1:0];
    end
  end

  // Exact magnitude of the anchor dot product
  assign score = res_sum[SUM_W-1] ? SUM_W'(-res_sum) : SUM_W'(res_sum);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (query_acc) state_nxt = ST_QSCORE;
      ST_QSCORE: state_nxt = ST_QWAIT;
      ST_QWAIT: begin
        if (res_score) state_nxt = (cnt_r == '0) ? ST_DONE : ST_PROD;
      end
      ST_PROD:   if (phase_r == 2'd3) state_nxt = ST_PWAIT;
      ST_PWAIT:  if (res_comp && (res_tag.comp == 2'd3)) state_nxt = ST_SCORE;
      ST_SCORE:  state_nxt = ST_SWAIT;
      ST_SWAIT: begin
        if (res_score) state_nxt = last_elem ? ST_DONE : ST_PROD;
      end
      ST_DONE:   if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: issue, table read, result load
  always_comb begin
    in_ready  = 1'b0;
    iss_tag   = '0;
    tbl_rd_en = 1'b0;
    rd_idx    = idx_r;
    out_load  = 1'b0;
    for (int k = 0; k < 4; k++) begin
      a_op[k] = q_e[k];
      b_op[k] = anc_e[k];
    end
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_QSCORE: begin
        iss_tag.valid = 1'b1;
        iss_tag.kind  = TAG_SCORE;
      end
      ST_QWAIT: begin
        tbl_rd_en = res_score && (cnt_r != '0);
      end
      ST_PROD: begin
        iss_tag.valid = 1'b1;
        iss_tag.kind  = TAG_COMP;
        iss_tag.comp  = phase_r;
        for (int k = 0; k < 4; k++) begin
          a_op[k] = s_e[k];
        end
        // operand order and signs of each conj(s) * q component
        case (phase_r)
          2'd0: begin
            b_op[0] = q_e[0]; b_op[1] = q_e[1]; b_op[2] = q_e[2]; b_op[3] = q_e[3];
          end
          2'd1: begin
            b_op[0] = q_e[1]; b_op[1] = q_n[0]; b_op[2] = q_n[3]; b_op[3] = q_e[2];
          end
          2'd2: begin
            b_op[0] = q_e[2]; b_op[1] = q_e[3]; b_op[2] = q_n[0]; b_op[3] = q_n[1];
          end
          default: begin
            b_op[0] = q_e[3]; b_op[1] = q_n[2]; b_op[2] = q_e[1]; b_op[3] = q_n[0];
          end
        endcase
      end
      ST_SCORE: begin
        iss_tag.valid = 1'b1;
        iss_tag.kind  = TAG_SCORE;
        for (int k = 0; k < 4; k++) begin
          a_op[k] = p_e[k];
        end
      end
      ST_SWAIT: begin
        rd_idx    = idx_r + SW'(1);
        tbl_rd_en = res_score && !last_elem;
      end
      ST_DONE: out_load = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  assign in_if.ready = in_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= (state_r == ST_PROD) ? phase_r + 2'd1 : 2'd0;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (query_acc) begin
      q_r[0] <= in_if.comp_w;
      q_r[1] <= in_if.comp_x;
      q_r[2] <= in_if.comp_y;
      q_r[3] <= in_if.comp_z;
      cnt_r  <= cnt_eff;
      idx_r  <= '0;
    end
    // candidate components as they leave the unit
    if (res_comp) begin
      p_r[res_tag.comp] <= comp_sat;
    end
    // query itself is the first candidate
    if ((state_r == ST_QWAIT) && res_score) begin
      best_score_r <= score;
      best_r       <= q_r;
      slot_r       <= SLOT_SELF;
    end
    // strictly greater score replaces the best
    if ((state_r == ST_SWAIT) && res_score) begin
      if (score > best_score_r) begin
        best_score_r <= score;
        best_r       <= p_r;
        slot_r       <= idx_r;
      end
      idx_r <= idx_r + SW'(1);
    end
    if (out_load) begin
      out_comp_r <= best_r;
      out_slot_r <= slot_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.best_w      = out_comp_r[0];
  assign out_if.best_x      = out_comp_r[1];
  assign out_if.best_y      = out_comp_r[2];
  assign out_if.best_z      = out_comp_r[3];
  assign out_if.chosen_slot = out_slot_r;

  // Element index stays inside the loaded range while elements are visited
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROD || state_r == ST_PWAIT || state_r == ST_SCORE ||
     state_r == ST_SWAIT) |-> (idx_r < cnt_r))
    else $error("element index past loaded count");

  // Winner is the query itself or a visited slot
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROD || state_r == ST_SWAIT || state_r == ST_DONE) |->
    (slot_r == SLOT_SELF || slot_r < cnt_r))
    else $error("chosen slot outside visited range");

  // Scores only come back while the sequencer waits for them
  a_score_wait: assert property (@(posedge clk) disable iff (!rst_n)
    res_score |-> (state_r == ST_QWAIT || state_r == ST_SWAIT))
    else $error("score result outside a wait step");

  // Nothing is in flight in the dot unit once the block is idle
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !res_tag.valid)
    else $error("dot unit busy while idle");

  // A finished query never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready && state_r == ST_DONE) |=> (state_r == ST_DONE))
    else $error("result overwritten while stalled");

endmodule

@@ hdl/scq_dot_unit.sv @@
// Shared four-lane multiply and sum unit, two register stages.
`timescale 1ns / 1ps

module scq_dot_unit #(
  parameter int OW = 17
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  scq_pkg::dot_tag_t       iss_tag,
  input  logic signed [OW-1:0]    a_op [4],
  input  logic signed [OW-1:0]    b_op [4],
  output scq_pkg::dot_tag_t       res_tag,
  output logic signed [2*OW+1:0]  res_sum
);
  import scq_pkg::*;

  localparam int PW    = 2 * OW;
  localparam int SUM_W = 2 * OW + 2;

  logic signed [PW-1:0]    prod_r [4];
  logic signed [SUM_W-1:0] sum_r;
  dot_tag_t                tag1_r;
  dot_tag_t                tag2_r;

  // Tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= iss_tag;
      tag2_r <= tag1_r;
    end
  end

  // Stage 1: lane products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      prod_r[k] <= a_op[k] * b_op[k];
    end
  end

  // Stage 2: exact sum of the four lanes
  always_ff @(posedge clk) begin
    sum_r <= SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);
  end

  assign res_tag = tag2_r;
  assign res_sum = sum_r;

endmodule

@@ hdl/scq_table.sv @@
// Symmetry element table: one write port, one registered read port.
`timescale 1ns / 1ps

module scq_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
